// ----- design/pidt_pkg.sv -----
package pidt_pkg;

    // Default sizing
    localparam int MAX_DEPTH_DEF   = 32;
    localparam int TAB_STOP_DEF    = 8;
    localparam int COLUMN_BITS_DEF = 10;

    // Fixed field widths
    localparam int KIND_W = 3;
    localparam int LINE_W = 24;
    localparam logic [LINE_W-1:0] LINE_MAX = {LINE_W{1'b1}};

    // Token kinds
    localparam logic [KIND_W-1:0] TK_NEWLINE   = 3'd0;
    localparam logic [KIND_W-1:0] TK_INDENT    = 3'd1;
    localparam logic [KIND_W-1:0] TK_DEDENT    = 3'd2;
    localparam logic [KIND_W-1:0] TK_BADDEDENT = 3'd3;
    localparam logic [KIND_W-1:0] TK_TOODEEP   = 3'd4;
    localparam logic [KIND_W-1:0] TK_END       = 3'd5;

    // Character codes
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_HASH  = 8'h23;

    // Controller to datapath
    typedef struct packed {
        logic accept;       // input transfer this cycle
        logic srch_miss;    // stack entry above the column: step down
        logic tgt_load;     // stack entry matched: take it as target
        logic tgt_zero;     // search ran out: target is column zero
        logic emit_first;   // first result of a dedent run
        logic emit_dedent;  // one DEDENT with pop
        logic emit_end;     // END token
        logic last;         // last_of_run for the emitted token
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic dedent_req;   // accepted byte starts a shallower line
        logic eoi_req;      // accepted item is end of input
        logic srch_empty;   // no stack entry left to search
        logic hit;          // read entry is at or below the column
        logic run_zero;     // no DEDENT left in the run
        logic run_one;      // one DEDENT left in the run
        logic out_free;     // output register can take a token
    } stat_t;

endpackage

// ----- design/pidt_in_if.sv -----
interface pidt_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_value;
    logic       end_of_input;
    logic       joined_line;

    modport source (output valid, byte_value, end_of_input, joined_line, input ready);
    modport sink   (input valid, byte_value, end_of_input, joined_line, output ready);
endinterface

// ----- design/pidt_out_if.sv -----
interface pidt_out_if #(
    parameter int COLUMN_BITS = pidt_pkg::COLUMN_BITS_DEF
);
    import pidt_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [KIND_W-1:0]      tok_kind;
    logic [LINE_W-1:0]      line_number;
    logic [COLUMN_BITS-1:0] indent_column;
    logic                   last_of_run;

    modport source (output valid, tok_kind, line_number, indent_column, last_of_run,
                    input ready);
    modport sink   (input valid, tok_kind, line_number, indent_column, last_of_run,
                    output ready);
endinterface

// ----- design/python_indent_dedent_tracker.sv -----
// NEWLINE, INDENT and too-deep tokens appear in the cycle after their byte is transferred.
// Throughput: one byte per cycle while the output drains; a dedent holds the input while
// the stack is searched entry by entry (registered read, then compare) and its tokens go out.
// End of input holds the input while a DEDENT per open level and then END are emitted.
// Reset: asynchronous, active low; the stack needs no clearing and is ready at once.
module python_indent_dedent_tracker #(
    parameter int MAX_DEPTH   = pidt_pkg::MAX_DEPTH_DEF,
    parameter int TAB_STOP    = pidt_pkg::TAB_STOP_DEF,
    parameter int COLUMN_BITS = pidt_pkg::COLUMN_BITS_DEF
) (
    input logic        clk,
    input logic        rst_n,
    pidt_in_if.sink    chars,
    pidt_out_if.source tokens
);
    import pidt_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    pidt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (chars.valid),
        .in_ready (chars.ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    pidt_dp #(
        .MAX_DEPTH   (MAX_DEPTH),
        .TAB_STOP    (TAB_STOP),
        .COLUMN_BITS (COLUMN_BITS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .byte_value    (chars.byte_value),
        .end_of_input  (chars.end_of_input),
        .joined_line   (chars.joined_line),
        .cmd           (cmd),
        .stat          (stat),
        .out_valid     (tokens.valid),
        .out_ready     (tokens.ready),
        .tok_kind      (tokens.tok_kind),
        .line_number   (tokens.line_number),
        .indent_column (tokens.indent_column),
        .last_of_run   (tokens.last_of_run)
    );
endmodule

// ----- design/pidt_ram.sv -----
module pidt_ram #(
    parameter int WIDTH = 10,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;
endmodule

// ----- design/pidt_ctrl.sv -----
module pidt_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  pidt_pkg::stat_t stat,
    output pidt_pkg::cmd_t  cmd
);
    import pidt_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_RD    = 3'd1;  // stack read issued
    localparam logic [2:0] S_CMP   = 3'd2;  // compare read data
    localparam logic [2:0] S_FIRST = 3'd3;  // DEDENT or bad dedent
    localparam logic [2:0] S_RUN   = 3'd4;  // remaining DEDENTs
    localparam logic [2:0] S_EOI   = 3'd5;  // closing DEDENTs and END

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready   = stat.out_free;
                cmd.accept = in_valid && stat.out_free;
                if (cmd.accept && stat.eoi_req)
                begin
                    state_next = S_EOI;
                end
                else if (cmd.accept && stat.dedent_req)
                begin
                    state_next = S_RD;
                end
            end
            S_RD:
            begin
                if (stat.srch_empty)
                begin
                    cmd.tgt_zero = 1'b1;
                    state_next   = S_FIRST;
                end
                else
                begin
                    state_next = S_CMP;
                end
            end
            S_CMP:
            begin
                if (stat.hit)
                begin
                    cmd.tgt_load = 1'b1;
                    state_next   = S_FIRST;
                end
                else
                begin
                    cmd.srch_miss = 1'b1;
                    state_next    = S_RD;
                end
            end
            S_FIRST:
            begin
                if (stat.out_free)
                begin
                    cmd.emit_first = 1'b1;
                    cmd.last       = stat.run_zero;
                    state_next     = stat.run_zero ? S_IDLE : S_RUN;
                end
            end
            S_RUN:
            begin
                if (stat.out_free)
                begin
                    cmd.emit_dedent = 1'b1;
                    cmd.last        = stat.run_one;
                    if (stat.run_one)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_EOI:
            begin
                if (stat.out_free)
                begin
                    if (stat.run_zero)
                    begin
                        cmd.emit_end = 1'b1;
                        cmd.last     = 1'b1;
                        state_next   = S_IDLE;
                    end
                    else
                    begin
                        cmd.emit_dedent = 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end
endmodule

// ----- design/pidt_dp.sv -----
module pidt_dp #(
    parameter int MAX_DEPTH   = pidt_pkg::MAX_DEPTH_DEF,
    parameter int TAB_STOP    = pidt_pkg::TAB_STOP_DEF,
    parameter int COLUMN_BITS = pidt_pkg::COLUMN_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [7:0]                  byte_value,
    input  logic                        end_of_input,
    input  logic                        joined_line,
    input  pidt_pkg::cmd_t              cmd,
    output pidt_pkg::stat_t             stat,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [pidt_pkg::KIND_W-1:0] tok_kind,
    output logic [pidt_pkg::LINE_W-1:0] line_number,
    output logic [COLUMN_BITS-1:0]      indent_column,
    output logic                        last_of_run
);
    import pidt_pkg::*;

    localparam int CW    = $clog2(MAX_DEPTH + 1);
    localparam int AW    = $clog2(MAX_DEPTH);
    localparam int PHW   = (TAB_STOP > 1) ? $clog2(TAB_STOP) : 1;
    localparam int SUM_W = ((COLUMN_BITS > 7) ? COLUMN_BITS : 7) + 1;
    localparam logic [COLUMN_BITS-1:0] COL_MAX = {COLUMN_BITS{1'b1}};
    localparam logic [CW-1:0]          DEPTH_C = CW'(MAX_DEPTH);
    localparam logic [PHW-1:0]         PH_LAST = PHW'(TAB_STOP - 1);

    // Line scanner state
    logic                   als_reg, als_next;
    logic                   cmt_reg, cmt_next;
    logic                   acr_reg, acr_next;
    logic                   halt_reg, halt_next;
    logic [COLUMN_BITS-1:0] lead_reg, lead_next;
    logic [PHW-1:0]         phase_reg, phase_next;
    logic [COLUMN_BITS-1:0] cur_reg, cur_next;
    logic [LINE_W-1:0]      line_reg, line_next;
    // Stack and dedent run
    logic [CW-1:0]          cnt_reg, cnt_next;
    logic [CW-1:0]          srch_reg, srch_next;
    logic [CW-1:0]          run_reg, run_next;
    logic [COLUMN_BITS-1:0] tgt_reg, tgt_next;
    // Output register
    logic                   ov_reg, ov_next;
    logic [KIND_W-1:0]      kind_reg;
    logic [LINE_W-1:0]      oline_reg;
    logic [COLUMN_BITS-1:0] ocol_reg;
    logic                   olast_reg;

    logic                   ld;
    logic [KIND_W-1:0]      ld_kind;
    logic [COLUMN_BITS-1:0] ld_col;
    logic                   ld_last;
    logic                   ram_we;
    logic [COLUMN_BITS-1:0] ram_rdata;
    logic [CW-1:0]          srch_dec;
    logic [SUM_W-1:0]       tab_sum;
    logic                   is_nl;
    logic                   cr_skip;

    assign srch_dec = srch_reg - CW'(1);
    assign tab_sum  = SUM_W'(lead_reg) + SUM_W'(TAB_STOP) - SUM_W'(phase_reg);
    assign is_nl    = (byte_value == CH_LF) || (byte_value == CH_CR);
    assign cr_skip  = acr_reg && (byte_value == CH_LF);

    pidt_ram #(
        .WIDTH (COLUMN_BITS),
        .DEPTH (MAX_DEPTH)
    ) u_stack (
        .clk   (clk),
        .we    (ram_we),
        .waddr (cnt_reg[AW-1:0]),
        .wdata (cur_reg),
        .raddr (srch_dec[AW-1:0]),
        .rdata (ram_rdata)
    );

    // Status to the controller, decoded from state, the offered item and out_ready
    always_comb
    begin
        stat            = '0;
        stat.dedent_req = !halt_reg && !end_of_input && !is_nl && !cmt_reg && als_reg
                          && (byte_value != CH_HASH) && (byte_value != CH_SPACE)
                          && (byte_value != CH_TAB) && (byte_value != CH_FF)
                          && (lead_reg < cur_reg);
        stat.eoi_req    = end_of_input && !halt_reg;
        stat.srch_empty = (srch_reg == '0);
        stat.hit        = (cur_reg >= ram_rdata);
        stat.run_zero   = (run_reg == '0);
        stat.run_one    = (run_reg == CW'(1));
        stat.out_free   = !ov_reg || out_ready;
    end

    // Scan, stack and token selection
    always_comb
    begin
        als_next   = als_reg;
        cmt_next   = cmt_reg;
        acr_next   = acr_reg;
        halt_next  = halt_reg;
        lead_next  = lead_reg;
        phase_next = phase_reg;
        cur_next   = cur_reg;
        line_next  = line_reg;
        cnt_next   = cnt_reg;
        srch_next  = srch_reg;
        run_next   = run_reg;
        tgt_next   = tgt_reg;
        ld         = 1'b0;
        ld_kind    = TK_NEWLINE;
        ld_col     = cur_reg;
        ld_last    = 1'b0;
        ram_we     = 1'b0;

        if (cmd.accept && !halt_reg)
        begin
            if (end_of_input)
            begin
                // close the line, then every open level
                acr_next   = 1'b0;
                cmt_next   = 1'b0;
                lead_next  = '0;
                phase_next = '0;
                if (!als_reg)
                begin
                    ld       = 1'b1;
                    ld_kind  = TK_NEWLINE;
                    als_next = 1'b1;
                end
                cur_next = '0;
                run_next = cnt_reg;
                cnt_next = '0;
            end
            else if (cr_skip)
            begin
                acr_next = 1'b0;
            end
            else if (is_nl)
            begin
                acr_next = (byte_value == CH_CR);
                cmt_next = 1'b0;
                if (als_reg)
                begin
                    lead_next  = '0;
                    phase_next = '0;
                end
                else if (!joined_line)
                begin
                    ld         = 1'b1;
                    ld_kind    = TK_NEWLINE;
                    ld_last    = 1'b1;
                    als_next   = 1'b1;
                    lead_next  = '0;
                    phase_next = '0;
                end
                if (line_reg != LINE_MAX)
                begin
                    line_next = line_reg + LINE_W'(1);
                end
            end
            else
            begin
                acr_next = 1'b0;
                priority if (cmt_reg)
                begin
                end
                else if (byte_value == CH_HASH)
                begin
                    cmt_next = 1'b1;
                end
                else if (!als_reg)
                begin
                end
                else if (byte_value == CH_SPACE)
                begin
                    if (lead_reg != COL_MAX)
                    begin
                        lead_next  = lead_reg + COLUMN_BITS'(1);
                        phase_next = (phase_reg == PH_LAST) ? '0 : phase_reg + PHW'(1);
                    end
                end
                else if (byte_value == CH_TAB)
                begin
                    lead_next  = (tab_sum > SUM_W'(COL_MAX)) ? COL_MAX
                                                              : tab_sum[COLUMN_BITS-1:0];
                    phase_next = '0;
                end
                else if (byte_value == CH_FF)
                begin
                    lead_next  = '0;
                    phase_next = '0;
                end
                else
                begin
                    // first real byte of the line
                    als_next   = 1'b0;
                    lead_next  = '0;
                    phase_next = '0;
                    if (lead_reg > cur_reg)
                    begin
                        ld      = 1'b1;
                        ld_last = 1'b1;
                        if (cnt_reg >= DEPTH_C)
                        begin
                            halt_next = 1'b1;
                            ld_kind   = TK_TOODEEP;
                        end
                        else
                        begin
                            ram_we   = 1'b1;
                            cnt_next = cnt_reg + CW'(1);
                            cur_next = lead_reg;
                            ld_kind  = TK_INDENT;
                            ld_col   = lead_reg;
                        end
                    end
                    else if (lead_reg < cur_reg)
                    begin
                        cur_next  = lead_reg;
                        srch_next = cnt_reg;
                        run_next  = '0;
                    end
                end
            end
        end

        // stack search
        if (cmd.srch_miss)
        begin
            run_next  = run_reg + CW'(1);
            srch_next = srch_dec;
        end
        if (cmd.tgt_load)
        begin
            tgt_next = ram_rdata;
        end
        if (cmd.tgt_zero)
        begin
            tgt_next = '0;
        end

        // dedent run and end of input tokens
        if (cmd.emit_first)
        begin
            ld      = 1'b1;
            ld_last = cmd.last;
            if (cur_reg != tgt_reg)
            begin
                ld_kind = TK_BADDEDENT;
            end
            else
            begin
                ld_kind = TK_DEDENT;
                if (cnt_reg != '0)
                begin
                    cnt_next = cnt_reg - CW'(1);
                end
            end
        end
        if (cmd.emit_dedent)
        begin
            ld       = 1'b1;
            ld_kind  = TK_DEDENT;
            ld_last  = cmd.last;
            run_next = run_reg - CW'(1);
            if (cnt_reg != '0)
            begin
                cnt_next = cnt_reg - CW'(1);
            end
        end
        if (cmd.emit_end)
        begin
            ld      = 1'b1;
            ld_kind = TK_END;
            ld_last = 1'b1;
        end

        ov_next = ld ? 1'b1 : (out_ready ? 1'b0 : ov_reg);
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            als_reg   <= 1'b1;
            cmt_reg   <= 1'b0;
            acr_reg   <= 1'b0;
            halt_reg  <= 1'b0;
            lead_reg  <= '0;
            phase_reg <= '0;
            cur_reg   <= '0;
            line_reg  <= LINE_W'(1);
            cnt_reg   <= '0;
            srch_reg  <= '0;
            run_reg   <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            als_reg   <= als_next;
            cmt_reg   <= cmt_next;
            acr_reg   <= acr_next;
            halt_reg  <= halt_next;
            lead_reg  <= lead_next;
            phase_reg <= phase_next;
            cur_reg   <= cur_next;
            line_reg  <= line_next;
            cnt_reg   <= cnt_next;
            srch_reg  <= srch_next;
            run_reg   <= run_next;
            ov_reg    <= ov_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        tgt_reg <= tgt_next;
        if (ld)
        begin
            kind_reg  <= ld_kind;
            oline_reg <= line_reg;
            ocol_reg  <= ld_col;
            olast_reg <= ld_last;
        end
    end

    assign out_valid     = ov_reg;
    assign tok_kind      = kind_reg;
    assign line_number   = oline_reg;
    assign indent_column = ocol_reg;
    assign last_of_run   = olast_reg;
endmodule

// ----- design/pidt_checker.sv -----
module pidt_checker #(
    parameter int COLUMN_BITS = pidt_pkg::COLUMN_BITS_DEF
) (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        out_valid,
    input logic                        out_ready,
    input logic [pidt_pkg::KIND_W-1:0] tok_kind,
    input logic [pidt_pkg::LINE_W-1:0] line_number,
    input logic [COLUMN_BITS-1:0]      indent_column,
    input logic                        last_of_run
);
    import pidt_pkg::*;

    // A stalled token stays offered
    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("token dropped while stalled");

    // A stalled token keeps its payload
    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(tok_kind) && $stable(line_number)
                                    && $stable(indent_column) && $stable(last_of_run))
        else $error("token payload changed while stalled");

    // Only defined kinds leave the block
    a_kind_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> tok_kind <= TK_END)
        else $error("undefined token kind");

    // END closes its run
    a_end_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && tok_kind == TK_END |-> last_of_run)
        else $error("END not marked last");

    // INDENT and too-deep are single-token runs
    a_indent_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (tok_kind == TK_INDENT || tok_kind == TK_TOODEEP) |-> last_of_run)
        else $error("INDENT or too-deep not marked last");
endmodule

bind python_indent_dedent_tracker pidt_checker #(
    .COLUMN_BITS (COLUMN_BITS)
) u_pidt_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .out_valid     (tokens.valid),
    .out_ready     (tokens.ready),
    .tok_kind      (tokens.tok_kind),
    .line_number   (tokens.line_number),
    .indent_column (tokens.indent_column),
    .last_of_run   (tokens.last_of_run)
);

// ----- bench/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
    import pidt_pkg::*;

    localparam int DEPTH = MAX_DEPTH_DEF;
    localparam int TAB_W = TAB_STOP_DEF;
    localparam int COL_W = COLUMN_BITS_DEF;
    localparam logic [COL_W-1:0] COL_SAT = {COL_W{1'b1}};
    localparam int RANDOM_ITEMS = 500;
    localparam int LONG_HOLD = 200;

    // One layout token as seen on the output channel
    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [LINE_W-1:0] line_nr;
        logic [COL_W-1:0]  column;
        logic              closing;
    } token_t;

    logic clk;
    logic rst_n;

    pidt_in_if chars_if ();
    pidt_out_if #(.COLUMN_BITS(COL_W)) tokens_if ();

    python_indent_dedent_tracker #(
        .MAX_DEPTH   (DEPTH),
        .TAB_STOP    (TAB_W),
        .COLUMN_BITS (COL_W)
    ) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .chars  (chars_if),
        .tokens (tokens_if)
    );

    // Layout tracking state of the predictor
    bit               at_start = 1'b1;
    bit               in_remark = 1'b0;
    bit               cr_seen = 1'b0;
    logic [COL_W-1:0] lead_col = '0;
    logic [COL_W-1:0] indent_now = '0;
    logic [COL_W-1:0] level_stack [DEPTH];
    int               level_count = 0;
    logic [LINE_W-1:0] line_no = 1;
    bit               frozen = 1'b0;

    token_t layout_tokens [$];
    token_t run_buf [$];
    token_t head_token;

    int  mismatches = 0;
    int  items_sent = 0;
    int  hold_request = 0;
    bit  no_idle = 1'b0;

    // Clock
    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // Gap length: mostly none, some short, a few long
    function automatic int pick_gap();
        int r;
        if (no_idle)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 70)
            return 0;
        if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Random byte other than CR or LF; a line opener also excludes whitespace and comment start
    function automatic logic [7:0] text_byte(input bit opener);
        logic [7:0] b;
        b = 8'($urandom_range(0, 255));
        while (b == CH_CR || b == CH_LF ||
               (opener && (b == CH_SPACE || b == CH_TAB || b == CH_FF || b == CH_HASH)))
            b = 8'($urandom_range(0, 255));
        return b;
    endfunction

    function automatic void emit(input logic [KIND_W-1:0] kind);
        run_buf.push_back('{kind, line_no, indent_now, 1'b0});
    endfunction

    // Predict the tokens caused by one accepted transfer
    task automatic predict_tokens(input logic [7:0] b, input logic eoi, input logic jn);
        token_t           tok;
        int               passed;
        int               t;
        int               stop;
        bit               searching;
        logic [COL_W-1:0] target;
        run_buf.delete();
        if (frozen)
        begin
            // halted until reset: everything is dropped
        end
        else if (eoi)
        begin
            cr_seen = 1'b0;
            in_remark = 1'b0;
            lead_col = '0;
            if (!at_start)
            begin
                emit(TK_NEWLINE);
                at_start = 1'b1;
            end
            indent_now = '0;
            for (int i = 0; i < level_count && i < DEPTH; i++)
                emit(TK_DEDENT);
            level_count = 0;
            emit(TK_END);
        end
        else if (cr_seen && b == CH_LF)
        begin
            // LF of a CRLF pair
            cr_seen = 1'b0;
        end
        else
        begin
            cr_seen = 1'b0;
            if (b == CH_CR || b == CH_LF)
            begin
                cr_seen = (b == CH_CR);
                in_remark = 1'b0;
                if (at_start)
                begin
                    lead_col = '0;
                end
                else if (!jn)
                begin
                    emit(TK_NEWLINE);
                    at_start = 1'b1;
                    lead_col = '0;
                end
                if (line_no != LINE_MAX)
                    line_no++;
            end
            else if (in_remark || !at_start)
            begin
                // comment text or code past the first byte
            end
            else if (b == CH_HASH)
            begin
                in_remark = 1'b1;
            end
            else if (b == CH_SPACE)
            begin
                if (lead_col != COL_SAT)
                    lead_col++;
            end
            else if (b == CH_TAB)
            begin
                stop = (int'(lead_col) / TAB_W + 1) * TAB_W;
                lead_col = (stop > int'(COL_SAT)) ? COL_SAT : COL_W'(stop);
            end
            else if (b == CH_FF)
            begin
                lead_col = '0;
            end
            else
            begin
                // first real byte: compare against the open levels
                at_start = 1'b0;
                if (lead_col > indent_now)
                begin
                    if (level_count >= DEPTH)
                    begin
                        frozen = 1'b1;
                        emit(TK_TOODEEP);
                    end
                    else
                    begin
                        level_stack[level_count] = indent_now;
                        level_count++;
                        indent_now = lead_col;
                        emit(TK_INDENT);
                    end
                end
                else if (lead_col < indent_now)
                begin
                    passed = 1;
                    t = level_count;
                    target = '0;
                    searching = 1'b1;
                    while (searching && t > 0)
                    begin
                        t--;
                        if (lead_col >= level_stack[t])
                            searching = 1'b0;
                        else
                            passed++;
                    end
                    if (passed <= level_count)
                        target = level_stack[level_count - passed];
                    indent_now = lead_col;
                    if (lead_col != target)
                    begin
                        emit(TK_BADDEDENT);
                    end
                    else
                    begin
                        emit(TK_DEDENT);
                        if (level_count > 0)
                            level_count--;
                    end
                    for (int i = 1; i < passed; i++)
                    begin
                        if (level_count > 0)
                            level_count--;
                        emit(TK_DEDENT);
                    end
                end
                lead_col = '0;
            end
        end
        if (run_buf.size() > 0)
        begin
            tok = run_buf.pop_back();
            tok.closing = 1'b1;
            run_buf.push_back(tok);
        end
        foreach (run_buf[i])
            layout_tokens.push_back(run_buf[i]);
    endtask

    // Offer one item and hold it until the transfer; entered at a falling edge
    task automatic send_item(input logic [7:0] b, input logic eoi, input logic jn);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            chars_if.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        chars_if.valid        <= 1'b1;
        chars_if.byte_value   <= b;
        chars_if.end_of_input <= eoi;
        chars_if.joined_line  <= jn;
        @(posedge clk);
        while (chars_if.ready !== 1'b1)
            @(posedge clk);
        predict_tokens(b, eoi, jn);
        items_sent++;
        @(negedge clk);
    endtask

    // Leading whitespace up to a column, tabs and spaces mixed at random
    task automatic send_indent(input int col);
        int at;
        int next_stop;
        at = 0;
        while (at < col)
        begin
            next_stop = (at / TAB_W + 1) * TAB_W;
            if (next_stop <= col && $urandom_range(0, 1) == 1)
            begin
                send_item(CH_TAB, 1'b0, 1'($urandom_range(0, 1)));
                at = next_stop;
            end
            else
            begin
                send_item(CH_SPACE, 1'b0, 1'($urandom_range(0, 1)));
                at++;
            end
        end
    endtask

    // LF, CR or CRLF, never joined
    task automatic send_line_end();
        case ($urandom_range(0, 2))
            0: send_item(CH_LF, 1'b0, 1'b0);
            1: send_item(CH_CR, 1'b0, 1'b0);
            default:
            begin
                send_item(CH_CR, 1'b0, 1'b0);
                send_item(CH_LF, 1'b0, 1'b0);
            end
        endcase
    endtask

    // Code lines at columns 2*k, each one a level deeper
    task automatic open_levels(input int from_step, input int to_step, input bit keep_open);
        for (int k = from_step; k <= to_step; k++)
        begin
            send_indent(2 * k);
            send_item(text_byte(1'b1), 1'b0, 1'b0);
            if (k < to_step || !keep_open)
                send_line_end();
        end
    endtask

    // Every token kind but too-deep, and the line-ending rules, on a short source
    task automatic test_directed_layout();
        send_item(8'hFF, 1'b0, 1'b1);
        send_item(CH_LF, 1'b0, 1'b0);
        send_item(CH_SPACE, 1'b0, 1'b0);
        send_item(CH_SPACE, 1'b0, 1'b0);
        send_item(8'h00, 1'b0, 1'b0);
        send_item(CH_CR, 1'b0, 1'b0);
        send_item(CH_LF, 1'b0, 1'b1);
        // comment-only line
        send_item(CH_TAB, 1'b0, 1'b0);
        send_item(CH_HASH, 1'b0, 1'b0);
        send_item(CH_LF, 1'b0, 1'b0);
        // indent, joined newline, then a trailing comment
        send_item(CH_TAB, 1'b0, 1'b0);
        send_item("a", 1'b0, 1'b0);
        send_item(CH_LF, 1'b0, 1'b1);
        send_item(CH_SPACE, 1'b0, 1'b0);
        send_item(CH_HASH, 1'b0, 1'b0);
        send_item(CH_LF, 1'b0, 1'b0);
        // form feed in the lead, then a column between levels
        send_item(CH_SPACE, 1'b0, 1'b0);
        send_item(CH_FF, 1'b0, 1'b0);
        send_item(CH_SPACE, 1'b0, 1'b0);
        send_item("b", 1'b0, 1'b0);
        send_item(CH_CR, 1'b0, 1'b0);
        // bare CR followed straight by code
        send_item("c", 1'b0, 1'b0);
        send_item(8'h5A, 1'b1, 1'b1);
        send_item(8'hA5, 1'b1, 1'b0);
    endtask

    // Leading column pinned at its maximum by tabs and spaces
    task automatic test_column_saturation();
        repeat (126) send_item(CH_TAB, 1'b0, 1'b0);
        repeat (20) send_item(CH_SPACE, 1'b0, 1'b1);
        repeat (3) send_item(CH_TAB, 1'b0, 1'b0);
        send_item("x", 1'b0, 1'b0);
        send_item(CH_LF, 1'b0, 1'b0);
        send_item(8'h00, 1'b1, 1'b0);
    endtask

    // Full stack: long bad-dedent run, then the longest end-of-input run
    task automatic test_full_stack();
        open_levels(1, DEPTH, 1'b0);
        send_item(CH_SPACE, 1'b0, 1'b0);
        send_item("b", 1'b0, 1'b0);
        send_item(CH_LF, 1'b0, 1'b0);
        // receiver backs off while the stack refills
        hold_request = LONG_HOLD;
        open_levels(1, DEPTH - 1, 1'b1);
        send_item(8'hC3, 1'b1, 1'b0);
    endtask

    // Random programs: code, blank and comment lines, noise, end of input
    task automatic test_random_programs();
        int stop_at;
        int kind;
        int pick;
        int col;
        stop_at = items_sent + RANDOM_ITEMS;
        while (items_sent < stop_at)
        begin
            if ($urandom_range(0, 29) == 0)
                no_idle = ~no_idle;
            kind = $urandom_range(0, 99);
            if (kind < 8)
            begin
                send_indent($urandom_range(0, 12));
                send_line_end();
            end
            else if (kind < 15)
            begin
                send_indent($urandom_range(0, 12));
                send_item(CH_HASH, 1'b0, 1'($urandom_range(0, 1)));
                repeat ($urandom_range(0, 4))
                    send_item(text_byte(1'b0), 1'b0, 1'($urandom_range(0, 1)));
                send_line_end();
            end
            else if (kind < 21 && level_count < DEPTH - 6)
            begin
                repeat ($urandom_range(1, 6))
                    send_item(8'($urandom_range(0, 255)), 1'b0, 1'($urandom_range(0, 1)));
            end
            else if (kind < 25)
            begin
                send_item(8'($urandom_range(0, 255)), 1'b1, 1'($urandom_range(0, 1)));
                if ($urandom_range(0, 3) == 0)
                    send_item(8'($urandom_range(0, 255)), 1'b1, 1'($urandom_range(0, 1)));
            end
            else
            begin
                // code line: same level, deeper, an open level, or anywhere below
                pick = $urandom_range(0, 99);
                if (pick < 30 || (pick < 65 && level_count >= DEPTH))
                    col = indent_now;
                else if (pick < 65)
                    col = indent_now + $urandom_range(1, 12);
                else if (pick < 85 && level_count > 0)
                    col = level_stack[$urandom_range(0, level_count - 1)];
                else
                    col = $urandom_range(0, indent_now);
                if (col > int'(COL_SAT))
                    col = COL_SAT;
                if ($urandom_range(0, 9) == 0)
                begin
                    send_indent($urandom_range(1, 20));
                    send_item(CH_FF, 1'b0, 1'($urandom_range(0, 1)));
                end
                send_indent(col);
                send_item(text_byte(1'b1), 1'b0, 1'($urandom_range(0, 1)));
                repeat ($urandom_range(0, 6))
                begin
                    if ($urandom_range(0, 7) == 0)
                        send_item($urandom_range(0, 1) ? CH_LF : CH_CR, 1'b0, 1'b1);
                    else
                        send_item(text_byte(1'b0), 1'b0, 1'($urandom_range(0, 1)));
                end
                send_line_end();
            end
        end
        no_idle = 1'b0;
    endtask

    // Overflow of the stack halts the block; later input is dropped
    task automatic test_too_deep();
        send_item(8'h3C, 1'b1, 1'b0);
        open_levels(1, DEPTH, 1'b0);
        send_indent(2 * DEPTH + 2);
        send_item("z", 1'b0, 1'b0);
        send_item(CH_LF, 1'b0, 1'b0);
        send_item("q", 1'b0, 1'b1);
        send_item(8'h00, 1'b1, 1'b0);
        send_item(CH_CR, 1'b0, 1'b0);
    endtask

    // Token receiver with random back-pressure and requested long holds
    initial
    begin : token_receiver
        int idle_left;
        idle_left = 0;
        tokens_if.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request > 0)
            begin
                idle_left = hold_request;
                hold_request = 0;
            end
            if (idle_left > 0)
            begin
                tokens_if.ready <= 1'b0;
                idle_left--;
            end
            else
            begin
                tokens_if.ready <= 1'b1;
                idle_left = pick_gap();
            end
        end
    end

    // Compare each token transfer with the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && tokens_if.valid === 1'b1 && tokens_if.ready === 1'b1)
        begin
            if (layout_tokens.size() == 0)
            begin
                $error("unexpected token: kind %0d line %0d column %0d",
                       tokens_if.tok_kind, tokens_if.line_number, tokens_if.indent_column);
                mismatches++;
            end
            else
            begin
                head_token = layout_tokens.pop_front();
                if (tokens_if.tok_kind !== head_token.kind)
                begin
                    $error("tok_kind: expected %0d, got %0d",
                           head_token.kind, tokens_if.tok_kind);
                    mismatches++;
                end
                if (tokens_if.line_number !== head_token.line_nr)
                begin
                    $error("line_number: expected %0d, got %0d",
                           head_token.line_nr, tokens_if.line_number);
                    mismatches++;
                end
                if (tokens_if.indent_column !== head_token.column)
                begin
                    $error("indent_column: expected %0d, got %0d",
                           head_token.column, tokens_if.indent_column);
                    mismatches++;
                end
                if (tokens_if.last_of_run !== head_token.closing)
                begin
                    $error("last_of_run: expected %0d, got %0d",
                           head_token.closing, tokens_if.last_of_run);
                    mismatches++;
                end
            end
        end
    end

    // Run limit
    initial
    begin
        #12_000_000;
        $display("python_indent_dedent_tracker verification failed");
        $finish;
    end

    // Test sequence
    initial
    begin
        rst_n = 1'b0;
        chars_if.valid = 1'b0;
        chars_if.byte_value = 8'h00;
        chars_if.end_of_input = 1'b0;
        chars_if.joined_line = 1'b0;
        foreach (level_stack[i])
            level_stack[i] = '0;
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_directed_layout();
        test_column_saturation();
        test_full_stack();
        test_random_programs();
        test_too_deep();

        // drain, then allow for tokens still in flight
        chars_if.valid <= 1'b0;
        while (layout_tokens.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        if (mismatches == 0)
            $display("python_indent_dedent_tracker verification clean");
        else
            $display("python_indent_dedent_tracker verification failed");
        $finish;
    end

endmodule

// ----- python_indent_dedent_tracker.f -----
design/pidt_pkg.sv
design/pidt_in_if.sv
design/pidt_out_if.sv
design/pidt_ram.sv
design/pidt_ctrl.sv
design/pidt_dp.sv
design/python_indent_dedent_tracker.sv
design/pidt_checker.sv
bench/tb_top.sv
